// ===== rtl/vmu_pkg.sv =====
// Shared constants of the vector magnitude unit: op field width and operation codes.
package vmu_pkg;

  // Width of the operation code field
  localparam int OP_W = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_EUCLID    = 2'd0;
  localparam logic [OP_W-1:0] OP_MINKOWSKI = 2'd1;
  localparam logic [OP_W-1:0] OP_ENERGY    = 2'd2;

endpackage

// ===== rtl/vmu_in_if.sv =====
// Input channel of the vector magnitude unit: op code and four signed components.
interface vmu_in_if #(
  parameter int DATA_WIDTH = 24
);
  logic                         valid;
  logic                         ready;
  logic [vmu_pkg::OP_W-1:0]     op;
  logic signed [DATA_WIDTH-1:0] comp_t;
  logic signed [DATA_WIDTH-1:0] comp_x;
  logic signed [DATA_WIDTH-1:0] comp_y;
  logic signed [DATA_WIDTH-1:0] comp_z;

  modport source (output valid, output op, output comp_t, output comp_x, output comp_y,
                  output comp_z, input ready);
  modport sink   (input valid, input op, input comp_t, input comp_x, input comp_y,
                  input comp_z, output ready);
endinterface

// ===== rtl/vmu_out_if.sv =====
// Result channel of the vector magnitude unit: saturated floor square root.
interface vmu_out_if #(
  parameter int DATA_WIDTH = 24
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] magnitude;

  modport source (output valid, output magnitude, input ready);
  modport sink   (input valid, input magnitude, output ready);
endinterface

// ===== rtl/vmu_isqrt.sv =====
// Pipelined restoring integer square root, one result bit per register stage.
module vmu_isqrt #(
  parameter int ROOT_W = 25
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2*ROOT_W-1:0]   in_radicand,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ROOT_W-1:0]     out_root
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 2;

  // Per-stage registers; index k holds the state after k+1 steps
  logic              vld_r  [ROOT_W];
  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [RAD_W-1:0]  rad_r  [ROOT_W];
  logic              rdy    [ROOT_W+1];

  assign rdy[ROOT_W] = out_ready;
  assign in_ready    = rdy[0];
  assign out_valid   = vld_r[ROOT_W-1];
  assign out_root    = root_r[ROOT_W-1];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic              vld_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  rad_in;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              take;

    if (k == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = in_radicand;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign rad_in  = rad_r[k-1];
    end

    // Stage loads when empty or when its content moves on
    assign rdy[k] = !vld_r[k] || rdy[k+1];

    // Bring down the next two radicand bits and try root*4+1
    assign rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        rem_r[k]  <= take ? (rem_sh - trial) : rem_sh;
        root_r[k] <= {root_in[ROOT_W-2:0], take};
        rad_r[k]  <= {rad_in[RAD_W-3:0], 2'b00};
      end
    end
  end

endmodule

// ===== rtl/vector_magnitude_unit_core.sv =====
// Top level of the vector magnitude unit: squares, quadratic form and pipelined square root.
//
// Takes an op code and four signed components per transfer and returns the floor square
// root of x^2+y^2+z^2 (op 0), |t^2-x^2-y^2-z^2| (op 1) or t^2+x^2+y^2+z^2 (op 2); op 3
// gives zero. All arithmetic is exact; the only overflow, op 2 with every component at
// the most negative value, saturates to all ones. One item enters per cycle unless stalled
// by the output; results leave in order via five front stages (absolute value, squaring,
// two adder stages, form select) and DATA_WIDTH+1 square-root stages, one root bit each.
// Every stage has its own valid bit and loads whenever it is empty, so bubbles close up
// and input is still taken while a finished result waits on the output.
module vector_magnitude_unit_core #(
  parameter int DATA_WIDTH = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  vmu_in_if.sink     in_ch,
  vmu_out_if.source  out_ch
);

  localparam int W      = DATA_WIDTH;
  localparam int SQ_W   = 2 * W;
  localparam int FORM_W = SQ_W + 1;
  localparam int ROOT_W = W + 1;
  localparam int OP_W   = vmu_pkg::OP_W;

  // Stage valids and load enables
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic isq_in_ready;

  // Stage 1: op and absolute values
  logic [OP_W-1:0] op1_r;
  logic [W-1:0]    at_r, ax_r, ay_r, az_r;
  // Stage 2: squares
  logic [OP_W-1:0] op2_r;
  logic [SQ_W-1:0] sqt_r, sqx_r, sqy_r, sqz_r;
  // Stage 3: partial sum
  logic [OP_W-1:0]   op3_r;
  logic [FORM_W-1:0] tt3_r, sxy_r, sqz3_r;
  // Stage 4: spatial sum
  logic [OP_W-1:0]   op4_r;
  logic [FORM_W-1:0] tt4_r, s3_r;
  // Stage 5: selected form
  logic [FORM_W-1:0] form_r;
  logic [FORM_W-1:0] form_nxt;

  logic [ROOT_W-1:0] root;

  // Load chain: a stage takes data when empty or when it is passing its content on
  assign rdy5        = !v5_r || isq_in_ready;
  assign rdy4        = !v4_r || rdy5;
  assign rdy3        = !v3_r || rdy4;
  assign rdy2        = !v2_r || rdy3;
  assign rdy1        = !v1_r || rdy2;
  assign in_ch.ready = rdy1;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_ch.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // Stage 1: magnitudes; the most negative value maps to 2^(W-1), which still fits W bits
  always_ff @(posedge clk) begin
    if (rdy1) begin
      op1_r <= in_ch.op;
      at_r  <= in_ch.comp_t[W-1] ? W'(~in_ch.comp_t + 1'b1) : W'(in_ch.comp_t);
      ax_r  <= in_ch.comp_x[W-1] ? W'(~in_ch.comp_x + 1'b1) : W'(in_ch.comp_x);
      ay_r  <= in_ch.comp_y[W-1] ? W'(~in_ch.comp_y + 1'b1) : W'(in_ch.comp_y);
      az_r  <= in_ch.comp_z[W-1] ? W'(~in_ch.comp_z + 1'b1) : W'(in_ch.comp_z);
    end
  end

  // Stage 2: four unsigned squares
  always_ff @(posedge clk) begin
    if (rdy2) begin
      op2_r <= op1_r;
      sqt_r <= SQ_W'(at_r) * SQ_W'(at_r);
      sqx_r <= SQ_W'(ax_r) * SQ_W'(ax_r);
      sqy_r <= SQ_W'(ay_r) * SQ_W'(ay_r);
      sqz_r <= SQ_W'(az_r) * SQ_W'(az_r);
    end
  end

  // Stage 3: x^2 + y^2
  always_ff @(posedge clk) begin
    if (rdy3) begin
      op3_r  <= op2_r;
      tt3_r  <= FORM_W'(sqt_r);
      sxy_r  <= FORM_W'(sqx_r) + FORM_W'(sqy_r);
      sqz3_r <= FORM_W'(sqz_r);
    end
  end

  // Stage 4: add z^2
  always_ff @(posedge clk) begin
    if (rdy4) begin
      op4_r <= op3_r;
      tt4_r <= tt3_r;
      s3_r  <= sxy_r + sqz3_r;
    end
  end

  // Stage 5: pick the quadratic form
  always_comb begin
    unique case (op4_r)
      vmu_pkg::OP_EUCLID:    form_nxt = s3_r;
      vmu_pkg::OP_MINKOWSKI: form_nxt = (tt4_r >= s3_r) ? (tt4_r - s3_r) : (s3_r - tt4_r);
      vmu_pkg::OP_ENERGY:    form_nxt = tt4_r + s3_r;
      default:               form_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      form_r <= form_nxt;
    end
  end

  // Square root over an even-width radicand
  vmu_isqrt #(
    .ROOT_W (ROOT_W)
  ) u_isqrt (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (v5_r),
    .in_ready    (isq_in_ready),
    .in_radicand ({1'b0, form_r}),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_root    (root)
  );

  // Root of 2^(2W) is 2^W: clamp to all ones
  assign out_ch.magnitude = root[W] ? {W{1'b1}} : root[W-1:0];

endmodule
